// ===== sv/lrufr_pkg.sv =====
// Package for the LRU frame replacement unit: request and status codes and
// the control bundle that drives the link store. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrufr_pkg;

    // Request codes carried on s_req_type
    localparam logic REQ_REFERENCE = 1'b0;
    localparam logic REQ_EVICT     = 1'b1;

    // Status codes carried on m_status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Per-cycle access controls from the sequencer to the link store
    typedef struct packed {
        logic rd_en;    // capture all three entries at rd_addr
        logic pres_we;  // write presence mark
        logic pres_wd;  // presence mark value
        logic nxt_we;   // write link toward the MRU end
        logic prv_we;   // write link toward the LRU end
    } lrufr_mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lrufr_links.sv =====
// Link store for the LRU frame replacement unit: presence marks and both
// list links, one write port per array and a shared registered read.
// Depends on lrufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrufr_links #(
    parameter int MAX_FRAMES = 64,
    parameter int IDX_W      = 6
) (
    input  wire logic                  aclk,
    input  wire lrufr_pkg::lrufr_mem_ctl_t ctl,
    input  wire logic [IDX_W-1:0]      rd_addr,
    input  wire logic [IDX_W-1:0]      pres_waddr,
    input  wire logic [IDX_W-1:0]      nxt_waddr,
    input  wire logic [IDX_W-1:0]      nxt_wdata,
    input  wire logic [IDX_W-1:0]      prv_waddr,
    input  wire logic [IDX_W-1:0]      prv_wdata,
    output logic                       pres_rd,
    output logic [IDX_W-1:0]           nxt_rd,
    output logic [IDX_W-1:0]           prv_rd
);

    logic             pres_mem [MAX_FRAMES];
    logic [IDX_W-1:0] nxt_mem  [MAX_FRAMES];
    logic [IDX_W-1:0] prv_mem  [MAX_FRAMES];

    // Hold read data until the next read is issued
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            pres_rd <= pres_mem[rd_addr];
            nxt_rd  <= nxt_mem[rd_addr];
            prv_rd  <= prv_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.pres_we) begin
            pres_mem[pres_waddr] <= ctl.pres_wd;
        end
        if (ctl.nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (ctl.prv_we) begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lru_frame_replacement_unit.sv =====
// Top level of the LRU frame replacement unit: sequencer, list ends,
// frame count and result register. Depends on lrufr_pkg and lrufr_links.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_req_type, s_frame_number
// m_        out  m_valid/m_ready    m_victim_frame, m_status, m_tracked_count
//
// Each request is accepted in ST_IDLE, then updated in ST_LOOK or ST_EVICT;
// a tracked frame in the middle of the list that moves to the MRU end also
// passes ST_LINK, since the link arrays have one write port each, so that
// relink needs two writes. After reset the unit sweeps the presence marks,
// one entry a cycle, over all MAX_FRAMES entries with s_ready low.
// A result waits in the output register while the next request is taken;
// every update step of that next request holds until m_ready frees it.

module lru_frame_replacement_unit #(
    parameter int MAX_FRAMES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [5:0] s_frame_number,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [5:0]      m_victim_frame,
    output logic            m_status,
    output logic [6:0]      m_tracked_count
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_LINK,
        ST_EVICT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] frame_reg, frame_next;
    logic             in_range_reg, in_range_next;
    logic [IDX_W-1:0] lru_reg, lru_next;
    logic [IDX_W-1:0] mru_reg, mru_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [5:0]       m_victim_reg, m_victim_next;
    logic             m_status_reg, m_status_next;
    logic [6:0]       m_count_reg, m_count_next;

    lrufr_pkg::lrufr_mem_ctl_t mem_ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] pres_waddr;
    logic [IDX_W-1:0] nxt_waddr, nxt_wdata;
    logic [IDX_W-1:0] prv_waddr, prv_wdata;
    logic             pres_rd;
    logic [IDX_W-1:0] nxt_rd, prv_rd;

    logic             accept;
    logic             out_free;

    lrufr_links #(
        .MAX_FRAMES(MAX_FRAMES),
        .IDX_W     (IDX_W)
    ) u_links (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .rd_addr   (rd_addr),
        .pres_waddr(pres_waddr),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .prv_waddr (prv_waddr),
        .prv_wdata (prv_wdata),
        .pres_rd   (pres_rd),
        .nxt_rd    (nxt_rd),
        .prv_rd    (prv_rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        logic             done;
        logic [IDX_W-1:0] victim;
        logic             status;

        done          = 1'b0;
        victim        = '0;
        status        = lrufr_pkg::STATUS_OK;

        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        frame_next    = frame_reg;
        in_range_next = in_range_reg;
        lru_next      = lru_reg;
        mru_next      = mru_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_victim_next = m_victim_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;

        mem_ctl    = '0;
        rd_addr    = frame_reg;
        pres_waddr = frame_reg;
        nxt_waddr  = mru_reg;
        nxt_wdata  = frame_reg;
        prv_waddr  = frame_reg;
        prv_wdata  = mru_reg;

        // Drop the result once the downstream side takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_ctl.pres_we = 1'b1;
                mem_ctl.pres_wd = 1'b0;
                pres_waddr      = clr_idx_reg;
                if (clr_idx_reg == IDX_W'(MAX_FRAMES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    // Fetch the entry of the named frame, or of the LRU end
                    mem_ctl.rd_en = 1'b1;
                    frame_next    = IDX_W'(s_frame_number);
                    in_range_next = (32'(s_frame_number) < 32'(MAX_FRAMES));
                    if (s_req_type == lrufr_pkg::REQ_EVICT) begin
                        rd_addr    = lru_reg;
                        state_next = ST_EVICT;
                    end else begin
                        rd_addr    = IDX_W'(s_frame_number);
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_LOOK: begin
                if (out_free) begin
                    if (!in_range_reg || (pres_rd && frame_reg == mru_reg)) begin
                        // Out of range, or already newest: order unchanged
                        done = 1'b1;
                    end else if (!pres_rd) begin
                        // Append a new frame at the MRU end
                        mem_ctl.pres_we = 1'b1;
                        mem_ctl.pres_wd = 1'b1;
                        if (count_reg == '0) begin
                            lru_next = frame_reg;
                        end else begin
                            mem_ctl.nxt_we = 1'b1;
                            mem_ctl.prv_we = 1'b1;
                        end
                        mru_next   = frame_reg;
                        count_next = count_reg + 1'b1;
                        done       = 1'b1;
                    end else if (frame_reg == lru_reg) begin
                        // Oldest frame moves up: advance the LRU end
                        lru_next       = nxt_rd;
                        mem_ctl.nxt_we = 1'b1;
                        mem_ctl.prv_we = 1'b1;
                        mru_next       = frame_reg;
                        done           = 1'b1;
                    end else begin
                        // Middle frame: unlink its neighbors first
                        mem_ctl.nxt_we = 1'b1;
                        nxt_waddr      = prv_rd;
                        nxt_wdata      = nxt_rd;
                        mem_ctl.prv_we = 1'b1;
                        prv_waddr      = nxt_rd;
                        prv_wdata      = prv_rd;
                        state_next     = ST_LINK;
                    end
                end
            end

            ST_LINK: begin
                if (out_free) begin
                    mem_ctl.nxt_we = 1'b1;
                    mem_ctl.prv_we = 1'b1;
                    mru_next       = frame_reg;
                    done           = 1'b1;
                end
            end

            ST_EVICT: begin
                if (out_free) begin
                    if (count_reg == '0) begin
                        status = lrufr_pkg::STATUS_EMPTY;
                    end else begin
                        victim          = lru_reg;
                        mem_ctl.pres_we = 1'b1;
                        mem_ctl.pres_wd = 1'b0;
                        pres_waddr      = lru_reg;
                        if (count_reg == CNT_W'(1)) begin
                            lru_next = '0;
                            mru_next = '0;
                        end else begin
                            lru_next = nxt_rd;
                        end
                        count_next = count_reg - 1'b1;
                    end
                    done = 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the result register and return for the next request
        if (done) begin
            m_valid_next  = 1'b1;
            m_victim_next = 6'(victim);
            m_status_next = status;
            m_count_next  = 7'(count_next);
            state_next    = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            lru_reg     <= '0;
            mru_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            lru_reg     <= lru_next;
            mru_reg     <= mru_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        frame_reg    <= frame_next;
        in_range_reg <= in_range_next;
        m_victim_reg <= m_victim_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_victim_frame  = m_victim_reg;
    assign m_status        = m_status_reg;
    assign m_tracked_count = m_count_reg;

endmodule

`default_nettype wire

// ===== sv/lrufr_checker.sv =====
// Port-level checker for the LRU frame replacement unit and the bind that
// attaches it to the top level. Depends on lrufr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrufr_checker #(
    parameter int MAX_FRAMES = 64
) (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_req_type,
    input wire logic [5:0] s_frame_number,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [5:0] m_victim_frame,
    input wire logic       m_status,
    input wire logic [6:0] m_tracked_count
);

    // A waiting request holds its payload until it is taken
    a_request_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_req_type)
            && $stable(s_frame_number)))
        else $error("waiting request changed");

    // An empty status carries no victim and an empty list
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == lrufr_pkg::STATUS_EMPTY)
            |-> (m_victim_frame == 6'd0 && m_tracked_count == 7'd0))
        else $error("empty status with nonzero victim or count");

    // The count never exceeds the number of frames
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_tracked_count) <= MAX_FRAMES))
        else $error("tracked count above frame total");

    // One request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in progress");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_victim_frame)
            && $stable(m_status) && $stable(m_tracked_count)))
        else $error("stalled result changed");

endmodule

bind lru_frame_replacement_unit lrufr_checker #(
    .MAX_FRAMES(MAX_FRAMES)
) u_lrufr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_req_type     (s_req_type),
    .s_frame_number (s_frame_number),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_victim_frame (m_victim_frame),
    .m_status       (m_status),
    .m_tracked_count(m_tracked_count)
);

`default_nettype wire
